// ----- sv/fpbcd_pkg.sv -----
// ----------------------------------------------------------------------------
// fpbcd_pkg: shared types and constants for the display frame block
// Field widths, register indexes and reset values, step sizing of the
// digit conversion and the power-of-ten helper used at elaboration.
// ----------------------------------------------------------------------------
package fpbcd_pkg;

  localparam int VALUE_W = 27;  // value in hundredths
  localparam int ADDR_W  = 4;   // driver digit address
  localparam int DATA_W  = 8;   // driver data byte
  localparam int CODE_W  = 4;   // one bcd digit or blank code
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;

  // conversion consumes this many value bits per cycle
  localparam int BITS_PER_STEP = 4;
  localparam int STEP_COUNT    = (VALUE_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SHIFT_W       = STEP_COUNT * BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(STEP_COUNT);

  localparam logic [DATA_W-1:0] POINT_BITS = 8'hF0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_CODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_DIGIT = 4'd1;

  // reset values
  localparam logic [CODE_W-1:0] BLANK_CODE_RST  = 4'd10;
  localparam logic [ADDR_W-1:0] POINT_DIGIT_RST = 4'd3;

  typedef logic [CODE_W-1:0] nibble_t;

  typedef struct packed {
    logic [CODE_W-1:0] blank_code;
    logic [ADDR_W-1:0] point_digit;
  } disp_cfg_t;

  function automatic int pow10(input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

endpackage

// ----- sv/fpbcd_if.sv -----
// ----------------------------------------------------------------------------
// fpbcd interfaces: request channels of the display frame block
// Value requests in, display frames out, and the register write channel.
// ----------------------------------------------------------------------------
interface fpbcd_value_if;
  logic                         valid;
  logic                         ready;
  logic [fpbcd_pkg::VALUE_W-1:0] value_hundredths;

  modport source (output valid, output value_hundredths, input ready);
  modport sink   (input valid, input value_hundredths, output ready);
endinterface

interface fpbcd_frame_if;
  logic                        valid;
  logic                        ready;
  logic [fpbcd_pkg::ADDR_W-1:0] digit_address;
  logic [fpbcd_pkg::DATA_W-1:0] digit_data;
  logic                        last_frame;

  modport source (output valid, output digit_address, output digit_data,
                  output last_frame, input ready);
  modport sink   (input valid, input digit_address, input digit_data,
                  input last_frame, output ready);
endinterface

interface fpbcd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpbcd_pkg::CFG_IDX_W-1:0]  index;
  logic [fpbcd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/fixed_point_to_bcd_display_frames.sv -----
// ----------------------------------------------------------------------------
// fixed_point_to_bcd_display_frames: value to display driver frames
// Converts a value in hundredths to DIGIT_COUNT decimal digits and emits
// one address/data frame per digit with leading-zero blanking.
// ----------------------------------------------------------------------------
// Each value request is saturated to all nines and turned into DIGIT_COUNT
// frames, address DIGIT_COUNT first down to address 1, last_frame marking the
// final one. Leading zeros carry blank_code (a zero value blanks every digit)
// and the frame whose address equals point_digit has 0xF0 ORed into its data.
// The converter loads each value and then pushes the 28 padded value bits
// four at a time through the row of digit cells, and the frame serialiser
// sends one frame per cycle while the frame side is ready, so a new value
// is taken while the previous frames still go out. Registers are written on
// the cfg channel, which is always ready; they are only to be changed while
// no value is in flight.
module fixed_point_to_bcd_display_frames #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic           clk,
  input  logic           rst,
  fpbcd_value_if.sink    values,
  fpbcd_frame_if.source  frames,
  fpbcd_cfg_if.sink      cfg
);

  // digits handed from converter to serialiser, digit k at bits 4k+3:4k
  logic [4*DIGIT_COUNT-1:0] digits;
  logic                     conv_valid;
  logic                     conv_ready;
  fpbcd_pkg::disp_cfg_t     disp_cfg;

  // register write channel never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_cfg.blank_code  <= fpbcd_pkg::BLANK_CODE_RST;
      disp_cfg.point_digit <= fpbcd_pkg::POINT_DIGIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        fpbcd_pkg::REG_BLANK_CODE:  disp_cfg.blank_code  <= cfg.data;
        fpbcd_pkg::REG_POINT_DIGIT: disp_cfg.point_digit <= cfg.data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // saturation and shift-and-add-3 through the digit cell row
  fpbcd_conv #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .values    (values),
    .out_valid (conv_valid),
    .out_ready (conv_ready),
    .digits    (digits)
  );

  // blanking, decimal point and frame sequencing
  fpbcd_frame #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .in_valid (conv_valid),
    .in_ready (conv_ready),
    .digits   (digits),
    .cfg      (disp_cfg),
    .frames   (frames)
  );

endmodule

// ----- sv/fpbcd_cell.sv -----
// ----------------------------------------------------------------------------
// fpbcd_cell: one bcd digit of the shift-and-add-3 converter
// Holds one decimal digit and runs four adjust-and-shift steps per cycle
// while step is high, taking bits from the lower cell and passing bits up.
// ----------------------------------------------------------------------------
module fpbcd_cell (
  input  logic                                clk,
  input  logic                                clear,
  input  logic                                step,
  input  logic [fpbcd_pkg::BITS_PER_STEP-1:0] shift_in,
  output logic [fpbcd_pkg::BITS_PER_STEP-1:0] shift_out,
  output fpbcd_pkg::nibble_t                  digit
);

  fpbcd_pkg::nibble_t digit_next;

  // bit for step j sits at position BITS_PER_STEP-1-j (msb first)
  always_comb begin
    fpbcd_pkg::nibble_t d;
    d = digit;
    shift_out = '0;
    for (int j = 0; j < fpbcd_pkg::BITS_PER_STEP; j++) begin
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      shift_out[fpbcd_pkg::BITS_PER_STEP-1-j] = d[3];
      d = {d[2:0], shift_in[fpbcd_pkg::BITS_PER_STEP-1-j]};
    end
    digit_next = d;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= '0;
    end else if (step) begin
      digit <= digit_next;
    end
  end

endmodule

// ----- sv/fpbcd_conv.sv -----
// ----------------------------------------------------------------------------
// fpbcd_conv: saturating binary to bcd converter
// Saturates the value, then clocks it through a row of digit cells four
// bits per cycle and offers the finished digits to the frame stage.
// ----------------------------------------------------------------------------
module fpbcd_conv #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  fpbcd_value_if.sink                       values,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [4*DIGIT_COUNT-1:0]          digits
);

  localparam logic [fpbcd_pkg::VALUE_W-1:0] Limit =
    fpbcd_pkg::VALUE_W'(fpbcd_pkg::pow10(DIGIT_COUNT) - 1);
  localparam logic [fpbcd_pkg::STEP_CNT_W-1:0] LastStep =
    fpbcd_pkg::STEP_CNT_W'(fpbcd_pkg::STEP_COUNT - 1);
  localparam int PadW = fpbcd_pkg::SHIFT_W - fpbcd_pkg::VALUE_W;

  logic                                   busy;
  logic                                   done;
  logic [fpbcd_pkg::STEP_CNT_W-1:0]       step_cnt;
  logic [fpbcd_pkg::SHIFT_W-1:0]          shreg;
  logic [fpbcd_pkg::VALUE_W-1:0]          sat_value;
  logic                                   accept;
  logic                                   take;
  logic [fpbcd_pkg::BITS_PER_STEP-1:0]    carry [DIGIT_COUNT+1];

  assign take          = done && out_ready;
  assign values.ready  = !busy && (!done || out_ready);
  assign accept        = values.valid && values.ready;
  assign out_valid     = done;
  assign sat_value     = (values.value_hundredths > Limit) ? Limit
                                                           : values.value_hundredths;

  // value bits enter the lowest cell msb first
  assign carry[0] = shreg[fpbcd_pkg::SHIFT_W-1 -: fpbcd_pkg::BITS_PER_STEP];

  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_cell
    fpbcd_cell u_cell (
      .clk       (clk),
      .clear     (accept),
      .step      (busy),
      .shift_in  (carry[k]),
      .shift_out (carry[k+1]),
      .digit     (digits[4*k +: 4])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= {{PadW{1'b0}}, sat_value};
    end else if (busy) begin
      shreg <= shreg << fpbcd_pkg::BITS_PER_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      if (accept) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == LastStep) begin
          busy <= 1'b0;
        end
      end
      if (busy && step_cnt == LastStep) begin
        done <= 1'b1;
      end else if (take) begin
        done <= 1'b0;
      end
    end
  end

  // saturated value always fits, nothing may leave the top cell
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    busy |-> carry[DIGIT_COUNT] == '0)
    else $error("bcd overflow out of top digit cell");

  a_busy_done_excl: assert property (@(posedge clk) disable iff (rst)
    !(busy && done))
    else $error("converter busy while holding a result");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && step_cnt == LastStep |=> done && !busy)
    else $error("conversion did not finish after last step");

endmodule

// ----- sv/fpbcd_frame.sv -----
// ----------------------------------------------------------------------------
// fpbcd_frame: display frame serialiser
// Walks the digits from the top address down, blanks leading zeros and
// sets the point bits, one frame per cycle while frames.ready is high.
// ----------------------------------------------------------------------------
module fpbcd_frame #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [4*DIGIT_COUNT-1:0] digits,
  input  fpbcd_pkg::disp_cfg_t     cfg,
  fpbcd_frame_if.source            frames
);

  localparam logic [fpbcd_pkg::ADDR_W-1:0] TopAddr = fpbcd_pkg::ADDR_W'(DIGIT_COUNT);
  localparam logic [fpbcd_pkg::ADDR_W-1:0] LastAddr = 4'd1;

  logic                              valid;
  logic [fpbcd_pkg::ADDR_W-1:0]      addr;
  logic [4*DIGIT_COUNT-1:0]          dreg;
  logic                              shown;
  fpbcd_pkg::nibble_t                cur;
  logic                              shown_now;
  logic                              last;
  logic                              sent;
  logic                              load;

  assign cur       = dreg[4*DIGIT_COUNT-1 -: 4];
  assign shown_now = shown || (cur != '0);
  assign last      = (addr == LastAddr);
  assign sent      = valid && frames.ready;
  assign in_ready  = !valid || (frames.ready && last);
  assign load      = in_valid && in_ready;

  always_comb begin
    frames.digit_data = shown_now ? {4'd0, cur} : {4'd0, cfg.blank_code};
    if (addr == cfg.point_digit) begin
      frames.digit_data = frames.digit_data | fpbcd_pkg::POINT_BITS;
    end
  end

  assign frames.valid         = valid;
  assign frames.digit_address = addr;
  assign frames.last_frame    = last;

  always_ff @(posedge clk) begin
    if (load) begin
      dreg  <= digits;
      addr  <= TopAddr;
      shown <= 1'b0;
    end else if (sent) begin
      dreg  <= dreg << 4;
      addr  <= addr - 1'b1;
      shown <= shown_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (sent && last) begin
      valid <= 1'b0;
    end
  end

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> addr >= LastAddr && addr <= TopAddr)
    else $error("frame address out of range");

  a_addr_walk: assert property (@(posedge clk) disable iff (rst)
    sent && !last |=> valid && addr == $past(addr) - 1'b1)
    else $error("frame address did not step down");

endmodule

// ----- tb/fpbcd_frame_checker.sv -----
// ----------------------------------------------------------------------------
// fpbcd_frame_checker: scoreboard for the display frame block
// Watches the value, frame and register channels, works out the DIGIT_COUNT
// frames that each accepted value must produce and compares every frame
// the block sends against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module fpbcd_frame_checker #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic   clk,
  input  logic   rst,
  fpbcd_value_if values,
  fpbcd_frame_if frames,
  fpbcd_cfg_if   cfg,
  output int     fail_count,
  output int     pending_frames,
  output int     value_count,
  output int     frame_count
);

  import fpbcd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] digit_address;
    logic [DATA_W-1:0] digit_data;
    logic              last_frame;
  } frame_t;

  frame_t            frame_q[$];
  logic [CODE_W-1:0] blank_code;
  logic [ADDR_W-1:0] point_digit;
  int                errors;
  int                values_seen;
  int                frames_seen;

  // DIGIT_COUNT frames per value, most significant digit first
  function automatic void predict_frames(input logic [VALUE_W-1:0] raw);
    longint unsigned ceiling;
    longint unsigned v;
    longint unsigned weight;
    int unsigned     d;
    logic            shown;
    frame_t          f;
    ceiling = 1;
    repeat (DIGIT_COUNT) ceiling = ceiling * 10;
    ceiling = ceiling - 1;
    v = raw;
    if (v > ceiling) v = ceiling;
    shown = 1'b0;
    for (int a = DIGIT_COUNT; a >= 1; a--) begin
      weight = 1;
      repeat (a - 1) weight = weight * 10;
      d = (v / weight) % 10;
      if (d != 0) shown = 1'b1;
      f.digit_address = ADDR_W'(a);
      f.digit_data    = shown ? DATA_W'(d) : DATA_W'(blank_code);
      if (point_digit == a) f.digit_data = f.digit_data | POINT_BITS;
      f.last_frame    = (a == 1);
      frame_q.push_back(f);
    end
  endfunction

  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (rst) begin
      blank_code  = BLANK_CODE_RST;
      point_digit = POINT_DIGIT_RST;
      frame_q.delete();
      errors      = 0;
      values_seen = 0;
      frames_seen = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_BLANK_CODE:  blank_code = cfg.data;
          REG_POINT_DIGIT: point_digit = cfg.data;
          default: ;
        endcase
      end
      if (values.valid && values.ready) begin
        predict_frames(values.value_hundredths);
        values_seen++;
      end
      if (frames.valid && frames.ready) begin
        frames_seen++;
        got.digit_address = frames.digit_address;
        got.digit_data    = frames.digit_data;
        got.last_frame    = frames.last_frame;
        if (frame_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("frame with no value behind it: addr %0d data %02h last %0b",
                     got.digit_address, got.digit_data, got.last_frame);
        end else begin
          want = frame_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display({"frame mismatch: expected addr %0d data %02h last %0b,",
                        " got addr %0d data %02h last %0b"},
                       want.digit_address, want.digit_data, want.last_frame,
                       got.digit_address, got.digit_data, got.last_frame);
          end
        end
      end
    end
    fail_count     <= errors;
    pending_frames <= frame_q.size();
    value_count    <= values_seen;
    frame_count    <= frames_seen;
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: top level for the display frame block
// Drives value requests and register writes, throttles the frame side and
// hands every channel to the frame checker, which reports mismatches; this
// module only decides when the run ends and whether it passed.
// ----------------------------------------------------------------------------
module tb;

  import fpbcd_pkg::*;

  localparam int DIGIT_COUNT     = 8;
  localparam int RESET_CYCLES    = 10;
  localparam int SETTLE_CYCLES   = 16;   // comfortably past the value-to-frame latency
  localparam int TAIL_CYCLES     = 32;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STALL_LIMIT     = 2000; // cycles with no request moving at all
  localparam int FULL_SCALE      = 99999999;

  logic clk = 1'b0;
  logic rst;
  logic hold_off = 1'b0;

  int send_idle_pct;
  int stall_pct;
  int settings_applied = 0;
  int quiet_cycles = 0;

  int fail_count;
  int pending_frames;
  int value_count;
  int frame_count;

  // directed values: extremes, blanking, saturation and digit patterns
  logic [VALUE_W-1:0] directed_values [18] = '{
    27'd0,        27'd1,        27'd5,        27'd9,
    27'd10,       27'd100,      27'd305,      27'd1000,
    27'd10203040, 27'd12345678, 27'd87654321, 27'd90000000,
    27'd10000000, 27'd99999998, 27'd99999999, 27'd100000000,
    27'd67108864, 27'd134217727
  };

  always #4 clk = ~clk;

  fpbcd_value_if values ();
  fpbcd_frame_if frames ();
  fpbcd_cfg_if   cfg ();

  fixed_point_to_bcd_display_frames #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .values (values),
    .frames (frames),
    .cfg    (cfg)
  );

  fpbcd_frame_checker #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) frame_check (
    .clk            (clk),
    .rst            (rst),
    .values         (values),
    .frames         (frames),
    .cfg            (cfg),
    .fail_count     (fail_count),
    .pending_frames (pending_frames),
    .value_count    (value_count),
    .frame_count    (frame_count)
  );

  // frame side: random back-pressure, plus a long hold-off when asked
  initial begin
    frames.ready <= 1'b0;
    forever begin
      @(posedge clk);
      frames.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog: any accepted request on any channel resets the count
  always @(posedge clk) begin
    if (rst || (values.valid && values.ready) || (frames.valid && frames.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // mix of shapes so that blanking depth, inner zeros and saturation all show
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned span;
    int unsigned v;
    span = 1;
    v    = 0;
    case ($urandom_range(5))
      0: v = $urandom_range((1 << VALUE_W) - 1, 0);
      1: v = $urandom_range((1 << VALUE_W) - 1, FULL_SCALE + 1);
      2: begin
        repeat ($urandom_range(8, 1)) span = span * 10;
        v = $urandom_range(span - 1, 0);
      end
      3: begin
        // about half the digits zero, leading ones included
        for (int k = 0; k < DIGIT_COUNT; k++)
          v = v * 10 + ($urandom_range(1) ? 0 : $urandom_range(9, 1));
      end
      4: v = $urandom_range(9, 0);
      default: v = FULL_SCALE - $urandom_range(20, 0);
    endcase
    return VALUE_W'(v);
  endfunction

  // valid stays high from one request to the next unless an idle gap falls
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      values.valid <= 1'b0;
      @(posedge clk);
    end
    values.valid            <= 1'b1;
    values.value_hundredths <= v;
    @(posedge clk);
    while (!values.ready) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_value(random_value());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // both registers, and optionally a write to an index past the list
  task automatic apply_setting(input logic [CODE_W-1:0] blank,
                               input logic [ADDR_W-1:0] point,
                               input bit                stray_write);
    write_reg(REG_BLANK_CODE, blank);
    write_reg(REG_POINT_DIGIT, point);
    if (stray_write)
      write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, 2)),
                CFG_DATA_W'($urandom_range((1 << CFG_DATA_W) - 1, 0)));
    cfg.valid <= 1'b0;
    settings_applied++;
  endtask

  // stop offering, let every frame out, then give the pipeline time to empty
  task automatic drain();
    values.valid <= 1'b0;
    @(posedge clk);
    while (pending_frames != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst                     <= 1'b1;
    values.valid            <= 1'b0;
    values.value_hundredths <= '0;
    cfg.valid               <= 1'b0;
    cfg.index               <= '0;
    cfg.data                <= '0;
    send_idle_pct = 32;
    stall_pct     = 82;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset settings: point on digit 3 covers a
    // pointed blank for the small values
    foreach (directed_values[i]) send_value(directed_values[i]);
    drain();

    // extremes of both registers: blank code zero, point on the top digit
    apply_setting(4'd0, 4'd8, 1'b0);
    send_random(30);
    drain();

    // sender now the slow side
    send_idle_pct = 82;
    stall_pct     = 32;
    apply_setting(4'd15, 4'd1, 1'b0);
    send_random(30);
    drain();

    // point address zero lights no digit; stray index must be dropped
    apply_setting(4'd7, 4'd0, 1'b1);
    send_random(20);
    drain();

    // no idling, and a long frame-side hold-off so the input backs up
    send_idle_pct = 0;
    stall_pct     = 0;
    apply_setting(CODE_W'($urandom_range(15, 0)), ADDR_W'($urandom_range(15, 9)), 1'b1);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_random(20);
    drain();

    apply_setting(CODE_W'($urandom_range(15, 0)), ADDR_W'($urandom_range(8, 1)), 1'b0);
    send_random(20);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d values and %0d frames across %0d register settings",
             value_count, frame_count, settings_applied);
    $display("including saturation, all-blank zero, unlit point and a backed-up input");
    if (fail_count == 0 && pending_frames == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- fixed_point_to_bcd_display_frames.f -----
sv/fpbcd_pkg.sv
sv/fpbcd_if.sv
sv/fpbcd_cell.sv
sv/fpbcd_conv.sv
sv/fpbcd_frame.sv
sv/fixed_point_to_bcd_display_frames.sv
tb/fpbcd_frame_checker.sv
tb/tb.sv
